### rtl/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg - shared types and constants for the integer matrix multiply unit
// Command codes, register indexes, reset values and the item structs.
// ----------------------------------------------------------------------------
`default_nettype none

package imm_pkg;

	localparam int DIM_DEFAULT = 16;

	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int DATA_W    = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 2'd2;

	// command codes; the fourth code is unused and does nothing
	localparam logic [1:0] CMD_WRITE_A = 2'd0;
	localparam logic [1:0] CMD_WRITE_B = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;

	typedef struct packed {
		logic [1:0]               cmd;
		logic [3:0]               row;
		logic [3:0]               col;
		logic signed [DATA_W-1:0] value;
	} cmd_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] product;
		logic                     index_error;
	} res_item_t;

endpackage

`default_nettype wire

### rtl/integer_matrix_multiply_unit.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply_unit - element-addressed integer matrix product
// Loads A and B one element per item; a read item returns one dot product.
// ----------------------------------------------------------------------------
// Writes: one item per cycle while idle, no result. Reads: the one multiply-accumulate
//   loop runs inner_len steps (inner_len capped at DIM) through the RAM read register,
//   product register and accumulator, then loads the output register; the next item
//   is taken once the result is loaded. Index-error reads and an empty sum skip the loop.
// Reset clears config registers to 16 and the state, step counter and valid flags;
//   the element stores are not cleared and hold garbage until written.
`default_nettype none

module integer_matrix_multiply_unit #(
	parameter int DIM = imm_pkg::DIM_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// command channel
	input  wire logic                         cmd_valid,
	output logic                              cmd_stall,
	input  wire imm_pkg::cmd_item_t           cmd_item,
	// result channel
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output imm_pkg::res_item_t                res_item,
	// configuration
	input  wire logic                         cfg_we,
	input  wire logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [imm_pkg::CFG_W-1:0]     cfg_data
);
	import imm_pkg::*;

	localparam int DEPTH = DIM * DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// counts 0..DIM
	localparam int CW    = $clog2(DIM + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;

	// configuration registers
	logic [CFG_W-1:0] a_rows_q, inner_len_q, b_cols_q;

	// clamped limits
	logic [CW-1:0] a_lim, inner_lim, b_lim;

	// dot-product loop
	logic [CW-1:0]     k_q, n_q;
	logic [AW-1:0]     a_ptr_q, b_ptr_q;
	logic              v_s1, v_s2;
	logic [DATA_W-1:0] a_rd_s1, b_rd_s1;
	logic [DATA_W-1:0] prod_s2;
	logic [DATA_W-1:0] acc_q;
	logic              err_q;

	// output register
	logic      res_valid_q;
	res_item_t res_q;

	logic          accept, wr_ok, rd_err, issue, out_load, loop_done;
	logic          a_we, b_we;
	logic [AW-1:0] wr_addr;

	// Registers above DIM act as DIM.
	always_comb begin
		a_lim     = (int'(a_rows_q) > DIM)    ? CW'(DIM) : CW'(a_rows_q);
		inner_lim = (int'(inner_len_q) > DIM) ? CW'(DIM) : CW'(inner_len_q);
		b_lim     = (int'(b_cols_q) > DIM)    ? CW'(DIM) : CW'(b_cols_q);
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && !cmd_stall;

	// writes outside the store are dropped
	assign wr_ok   = (int'(cmd_item.row) < DIM) && (int'(cmd_item.col) < DIM);
	assign wr_addr = AW'(int'(cmd_item.row) * DIM + int'(cmd_item.col));
	assign a_we    = accept && (cmd_item.cmd == CMD_WRITE_A) && wr_ok;
	assign b_we    = accept && (cmd_item.cmd == CMD_WRITE_B) && wr_ok;

	// zero limits make every read an error since row/col >= 0
	assign rd_err = (int'(cmd_item.row) >= int'(a_lim)) ||
		(int'(cmd_item.col) >= int'(b_lim));

	assign issue     = (state_q == S_RUN) && (k_q != n_q);
	assign loop_done = (state_q == S_RUN) && (k_q == n_q) && !v_s1 && !v_s2;
	assign out_load  = (state_q == S_DONE) && (!res_valid_q || !res_stall);

	// element stores; A walks along a row, B down a column
	imm_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (wr_addr),
		.wdata (cmd_item.value),
		.re    (issue),
		.raddr (a_ptr_q),
		.rdata (a_rd_s1)
	);

	imm_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (wr_addr),
		.wdata (cmd_item.value),
		.re    (issue),
		.raddr (b_ptr_q),
		.rdata (b_rd_s1)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q    <= CFG_RESET;
			inner_len_q <= CFG_RESET;
			b_cols_q    <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_A_ROWS:    a_rows_q    <= cfg_data;
				REG_INNER_LEN: inner_len_q <= cfg_data;
				REG_B_COLS:    b_cols_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (issue) begin
				k_q <= CW'(k_q + 1'b1);
			end

			case (state_q)
				S_IDLE: begin
					if (accept && (cmd_item.cmd == CMD_READ)) begin
						k_q <= '0;
						if (rd_err || (inner_lim == '0)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (loop_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept && (cmd_item.cmd == CMD_READ)) begin
			n_q     <= inner_lim;
			a_ptr_q <= AW'(int'(cmd_item.row) * DIM);
			b_ptr_q <= AW'(cmd_item.col);
			acc_q   <= '0;
			err_q   <= rd_err;
		end else begin
			if (issue) begin
				a_ptr_q <= AW'(a_ptr_q + 1'b1);
				b_ptr_q <= AW'(int'(b_ptr_q) + DIM);
			end
			if (v_s2) begin
				acc_q <= acc_q + prod_s2;
			end
		end
		// low 32 bits of the product are the same signed or unsigned
		if (v_s1) begin
			prod_s2 <= DATA_W'(a_rd_s1 * b_rd_s1);
		end
		if (out_load) begin
			res_q.product     <= err_q ? '0 : acc_q;
			res_q.index_error <= err_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

`default_nettype wire

### rtl/imm_ram.sv
// ----------------------------------------------------------------------------
// imm_ram - single-port-write, single-port-read matrix element store
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module imm_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [imm_pkg::DATA_W-1:0] wdata,
	input  wire logic                      re,
	input  wire logic [AW-1:0]             raddr,
	output logic      [imm_pkg::DATA_W-1:0] rdata
);
	import imm_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/imm_checker.sv
// ----------------------------------------------------------------------------
// imm_checker - port-level checks for the integer matrix multiply unit
// Watches the command and result channels; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module imm_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                cmd_valid,
	input wire logic                cmd_stall,
	input wire imm_pkg::cmd_item_t  cmd_item,
	input wire logic                res_valid,
	input wire logic                res_stall,
	input wire imm_pkg::res_item_t  res_item
);
	import imm_pkg::*;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res_item)))
		else $error("result changed while stalled");

	// an accepted read makes the block busy in the following cycle
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall && (cmd_item.cmd == CMD_READ)) |=> cmd_stall)
		else $error("read accepted without going busy");

	// writes never produce a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall && !res_valid &&
		 ((cmd_item.cmd == CMD_WRITE_A) || (cmd_item.cmd == CMD_WRITE_B)))
		|=> !res_valid)
		else $error("result after a write");

	// an error result carries zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_item.index_error) |-> (res_item.product == '0))
		else $error("index error with nonzero product");

	// a new result only appears at the end of a busy period
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_stall))
		else $error("result without a busy period");

endmodule

bind integer_matrix_multiply_unit imm_checker u_imm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd_item  (cmd_item),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_item  (res_item)
);

`default_nettype wire
